// ----- hdl/wth_pkg.sv -----
package wth_pkg;

    // CORDIC iteration count, valid from 8 to 32
    localparam int CORDIC_STAGES = 16;
    // width of a CORDIC stage index
    localparam int STG_W = 5;
    // CORDIC datapath width (Q30 values with headroom)
    localparam int CW = 34;
    // quotient bits of the crosswind ratio and the restoring-divider depth
    localparam int QW = 31;
    localparam int DIV_STEPS = QW;
    // divider remainder width
    localparam int RW = 48;
    // square root datapath width and step count
    localparam int SW = 62;
    localparam int SQRT_STEPS = 31;
    // bit position of the first root trial bit (2^60 = 1.0 squared in Q30)
    localparam int SQRT_TOP = 60;

    localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;
    localparam logic [SW-1:0] ONE_SQ = 62'h1000_0000_0000_0000;
    localparam logic [15:0] TAS_MIN = 16'd1;
    localparam logic [15:0] HALF_TURN = 16'h8000;

    // result status codes
    typedef logic [1:0] t_status;
    localparam t_status ST_SOLVED = 2'd0;
    localparam t_status ST_STRONG = 2'd1;
    localparam t_status ST_SLOW   = 2'd2;

    // side data that travels with an item through every cell
    typedef struct packed {
        logic [15:0]        ws;
        logic [15:0]        tas;
        logic [15:0]        wd;
        logic [15:0]        crs;
        logic               flip;
        logic signed [31:0] cs;
        logic               neg;
        logic               kite;
        logic               low;
        logic signed [31:0] s;
        logic [QW-1:0]      c;
    } t_ctx;

    // arctan(2^-i) in 2^32-per-turn units
    function automatic logic [31:0] atan_turn(input logic [STG_W-1:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- hdl/wth_rot_cell.sv -----
module wth_rot_cell (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [wth_pkg::STG_W-1:0]       i_stage,
    input  logic                            i_valid,
    input  logic signed [wth_pkg::CW-1:0]   i_x,
    input  logic signed [wth_pkg::CW-1:0]   i_y,
    input  logic signed [wth_pkg::CW-1:0]   i_z,
    input  wth_pkg::t_ctx                   i_ctx,
    output logic                            o_valid,
    output logic signed [wth_pkg::CW-1:0]   o_x,
    output logic signed [wth_pkg::CW-1:0]   o_y,
    output logic signed [wth_pkg::CW-1:0]   o_z,
    output wth_pkg::t_ctx                   o_ctx
);
    import wth_pkg::*;

    logic                 r_valid;
    logic signed [CW-1:0] r_x, r_y, r_z;
    t_ctx                 r_ctx;
    logic signed [CW-1:0] dx, dy, da;

    // shifted terms and angle step of this stage
    assign dx = i_y >>> i_stage;
    assign dy = i_x >>> i_stage;
    assign da = signed'({{(CW-32){1'b0}}, atan_turn(i_stage)});

    // advance the valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // rotate toward zero residual angle
    always_ff @(posedge i_clk) begin
        r_ctx <= i_ctx;
        if (!i_z[CW-1]) begin
            r_x <= i_x - dx;
            r_y <= i_y + dy;
            r_z <= i_z - da;
        end else begin
            r_x <= i_x + dx;
            r_y <= i_y - dy;
            r_z <= i_z + da;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_ctx   = r_ctx;

endmodule

// ----- hdl/wth_div_cell.sv -----
module wth_div_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [wth_pkg::STG_W-1:0]   i_shift,
    input  logic                        i_valid,
    input  logic [wth_pkg::RW-1:0]      i_rem,
    input  logic [wth_pkg::QW-1:0]      i_quo,
    input  wth_pkg::t_ctx               i_ctx,
    output logic                        o_valid,
    output logic [wth_pkg::RW-1:0]      o_rem,
    output logic [wth_pkg::QW-1:0]      o_quo,
    output wth_pkg::t_ctx               o_ctx
);
    import wth_pkg::*;

    logic          r_valid;
    logic [RW-1:0] r_rem;
    logic [QW-1:0] r_quo;
    t_ctx          r_ctx;
    logic [RW-1:0] trial;
    logic          ge;

    // divisor aligned to this quotient bit
    assign trial = {{(RW-16){1'b0}}, i_ctx.tas} << i_shift;
    assign ge    = (i_rem >= trial);

    // advance the valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // subtract when it fits and shift in the quotient bit
    always_ff @(posedge i_clk) begin
        r_ctx <= i_ctx;
        r_rem <= ge ? (i_rem - trial) : i_rem;
        r_quo <= {i_quo[QW-2:0], ge};
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;
    assign o_ctx   = r_ctx;

endmodule

// ----- hdl/wth_sqrt_cell.sv -----
module wth_sqrt_cell (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [5:0]              i_pos,
    input  logic                    i_valid,
    input  logic [wth_pkg::SW-1:0]  i_v,
    input  logic [wth_pkg::SW-1:0]  i_res,
    input  wth_pkg::t_ctx           i_ctx,
    output logic                    o_valid,
    output logic [wth_pkg::SW-1:0]  o_v,
    output logic [wth_pkg::SW-1:0]  o_res,
    output wth_pkg::t_ctx           o_ctx
);
    import wth_pkg::*;

    logic          r_valid;
    logic [SW-1:0] r_v, r_res;
    t_ctx          r_ctx;
    logic [SW-1:0] bitv, t;
    logic          ge;

    // trial value for this root bit
    assign bitv = {{(SW-1){1'b0}}, 1'b1} << i_pos;
    assign t    = i_res + bitv;
    assign ge   = (i_v >= t);

    // advance the valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // take the bit when the remainder allows it
    always_ff @(posedge i_clk) begin
        r_ctx <= i_ctx;
        r_v   <= ge ? (i_v - t) : i_v;
        r_res <= ge ? ((i_res >> 1) + bitv) : (i_res >> 1);
    end

    assign o_valid = r_valid;
    assign o_v     = r_v;
    assign o_res   = r_res;
    assign o_ctx   = r_ctx;

endmodule

// ----- hdl/wth_vec_cell.sv -----
module wth_vec_cell (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [wth_pkg::STG_W-1:0]       i_stage,
    input  logic                            i_valid,
    input  logic signed [wth_pkg::CW-1:0]   i_x,
    input  logic signed [wth_pkg::CW-1:0]   i_y,
    input  logic signed [wth_pkg::CW-1:0]   i_z,
    input  wth_pkg::t_ctx                   i_ctx,
    output logic                            o_valid,
    output logic signed [wth_pkg::CW-1:0]   o_x,
    output logic signed [wth_pkg::CW-1:0]   o_y,
    output logic signed [wth_pkg::CW-1:0]   o_z,
    output wth_pkg::t_ctx                   o_ctx
);
    import wth_pkg::*;

    logic                 r_valid;
    logic signed [CW-1:0] r_x, r_y, r_z;
    t_ctx                 r_ctx;
    logic signed [CW-1:0] dx, dy, da;

    // shifted terms and angle step of this stage
    assign dx = i_y >>> i_stage;
    assign dy = i_x >>> i_stage;
    assign da = signed'({{(CW-32){1'b0}}, atan_turn(i_stage)});

    // advance the valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // rotate the vector onto the x axis, accumulate the angle
    always_ff @(posedge i_clk) begin
        r_ctx <= i_ctx;
        if (!i_y[CW-1]) begin
            r_x <= i_x + dx;
            r_y <= i_y - dy;
            r_z <= i_z + da;
        end else begin
            r_x <= i_x - dx;
            r_y <= i_y + dy;
            r_z <= i_z - da;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_ctx   = r_ctx;

endmodule

// ----- hdl/wind_triangle_heading_core.sv -----
// Wind triangle solver: from wind speed, true airspeed (1/16 kt), wind direction and
// desired course (16-bit binary angles) it returns the heading to fly, the ground speed
// and a status (solved, wind too strong, airspeed too low). The block is a fixed-latency
// pipeline of cells: 16 CORDIC rotation cells for sine and cosine, 31 restoring-divide
// cells for the crosswind ratio, 31 square-root cells and 16 CORDIC vectoring cells for
// the arcsine, with a few multiply stages between. busy stays low, so an item may be
// started in every clock cycle; its result appears on o_strobe in start order.
// The receiver cannot stall the block.
module wind_triangle_heading_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [15:0]        i_wind_speed,
    input  logic [15:0]        i_true_airspeed,
    input  logic [15:0]        i_wind_direction,
    input  logic [15:0]        i_desired_course,
    output logic               o_strobe,
    output logic [15:0]        o_heading,
    output logic signed [17:0] o_ground_speed,
    output logic [1:0]         o_status
);
    import wth_pkg::*;

    localparam int NR = CORDIC_STAGES;

    // input stage
    logic        r_in_valid;
    t_ctx        r_in_ctx;
    logic [15:0] d;
    logic [31:0] u, uz;
    logic        flip;
    t_ctx        in_ctx;

    // rotation chain
    logic                 rot_v [0:NR];
    logic signed [CW-1:0] rot_x [0:NR];
    logic signed [CW-1:0] rot_y [0:NR];
    logic signed [CW-1:0] rot_z [0:NR];
    t_ctx                 rot_c [0:NR];

    // sine/cosine, product, magnitude stages
    logic               r_a_valid, r_b_valid, r_c_valid;
    t_ctx               r_a_ctx, r_b_ctx, r_c_ctx;
    t_ctx               n_a_ctx, n_c_ctx;
    logic signed [31:0] r_a_sn;
    logic signed [CW-1:0] sn_full, cs_full;
    logic signed [48:0] r_b_num;
    logic [48:0]        mag;
    logic [RW-1:0]      r_c_mag;

    // divide chain
    logic          div_v [0:DIV_STEPS];
    logic [RW-1:0] div_r [0:DIV_STEPS];
    logic [QW-1:0] div_q [0:DIV_STEPS];
    t_ctx          div_c [0:DIV_STEPS];

    // ratio, square, radicand stages
    logic               r_d_valid, r_e_valid, r_f_valid;
    t_ctx               r_d_ctx, r_e_ctx, r_f_ctx;
    t_ctx               n_d_ctx;
    logic signed [31:0] s_val;
    logic signed [63:0] r_e_sq;
    logic [SW-1:0]      r_f_v;

    // square root chain
    logic          sq_v [0:SQRT_STEPS];
    logic [SW-1:0] sq_r [0:SQRT_STEPS];
    logic [SW-1:0] sq_res [0:SQRT_STEPS];
    t_ctx          sq_c [0:SQRT_STEPS];

    // vectoring chain
    logic                 vec_v [0:NR];
    logic signed [CW-1:0] vec_x [0:NR];
    logic signed [CW-1:0] vec_y [0:NR];
    logic signed [CW-1:0] vec_z [0:NR];
    t_ctx                 vec_c [0:NR];
    t_ctx                 vec_ctx0;

    // product and output stages
    logic                 r_p_valid;
    t_ctx                 r_p_ctx;
    logic [46:0]          r_p_p1;
    logic signed [48:0]   r_p_p2;
    logic [15:0]          r_p_hd;
    logic signed [CW-1:0] zr;
    logic signed [49:0]   sum, g;
    logic signed [17:0]   gs_sat;
    t_status              stat;

    logic                 r_o_valid;
    logic [15:0]          r_o_heading;
    logic signed [17:0]   r_o_gs;
    t_status              r_o_status;

    assign busy = 1'b0;

    // register the item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_ctx <= in_ctx;
    end

    always_comb begin
        in_ctx        = '0;
        in_ctx.ws     = i_wind_speed;
        in_ctx.tas    = i_true_airspeed;
        in_ctx.wd     = i_wind_direction;
        in_ctx.crs    = i_desired_course;
        in_ctx.low    = (i_true_airspeed <= TAS_MIN);
    end

    // fold the relative wind angle into the right half plane
    assign d    = r_in_ctx.wd - r_in_ctx.crs;
    assign u    = {d, 16'h0000};
    assign flip = u[31] ^ u[30];
    assign uz   = flip ? (u + 32'h8000_0000) : u;

    always_comb begin
        rot_c[0]      = r_in_ctx;
        rot_c[0].flip = flip;
    end

    assign rot_v[0] = r_in_valid;
    assign rot_x[0] = GAIN_Q30;
    assign rot_y[0] = '0;
    assign rot_z[0] = signed'({{(CW-32){uz[31]}}, uz});

    for (genvar i = 0; i < NR; i++) begin : g_rot
        wth_rot_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (STG_W'(i)),
            .i_valid (rot_v[i]),
            .i_x     (rot_x[i]),
            .i_y     (rot_y[i]),
            .i_z     (rot_z[i]),
            .i_ctx   (rot_c[i]),
            .o_valid (rot_v[i+1]),
            .o_x     (rot_x[i+1]),
            .o_y     (rot_y[i+1]),
            .o_z     (rot_z[i+1]),
            .o_ctx   (rot_c[i+1])
        );
    end

    // undo the half-turn fold
    assign sn_full = rot_c[NR].flip ? -rot_y[NR] : rot_y[NR];
    assign cs_full = rot_c[NR].flip ? -rot_x[NR] : rot_x[NR];

    // ws*sin, then magnitude and the too-strong test
    assign mag = r_b_num[48] ? 49'(-r_b_num) : 49'(r_b_num);

    always_comb begin
        n_a_ctx    = rot_c[NR];
        n_a_ctx.cs = cs_full[31:0];
    end

    always_comb begin
        n_c_ctx      = r_b_ctx;
        n_c_ctx.neg  = r_b_num[48];
        n_c_ctx.kite = (mag > ({{33{1'b0}}, r_b_ctx.tas} << 30));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            r_a_valid <= rot_v[NR];
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_ctx <= n_a_ctx;
        r_a_sn  <= sn_full[31:0];
        r_b_ctx <= r_a_ctx;
        r_b_num <= signed'({1'b0, r_a_ctx.ws}) * r_a_sn;
        r_c_ctx <= n_c_ctx;
        r_c_mag <= mag[RW-1:0];
    end

    assign div_v[0] = r_c_valid;
    assign div_r[0] = r_c_mag;
    assign div_q[0] = '0;
    assign div_c[0] = r_c_ctx;

    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
        wth_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (STG_W'(DIV_STEPS - 1 - i)),
            .i_valid (div_v[i]),
            .i_rem   (div_r[i]),
            .i_quo   (div_q[i]),
            .i_ctx   (div_c[i]),
            .o_valid (div_v[i+1]),
            .o_rem   (div_r[i+1]),
            .o_quo   (div_q[i+1]),
            .o_ctx   (div_c[i+1])
        );
    end

    // signed ratio, its square and the radicand 1 - s^2
    assign s_val = div_c[DIV_STEPS].neg ? -signed'({1'b0, div_q[DIV_STEPS]})
                                        : signed'({1'b0, div_q[DIV_STEPS]});

    always_comb begin
        n_d_ctx   = div_c[DIV_STEPS];
        n_d_ctx.s = s_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
            r_f_valid <= 1'b0;
        end else begin
            r_d_valid <= div_v[DIV_STEPS];
            r_e_valid <= r_d_valid;
            r_f_valid <= r_e_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_ctx <= n_d_ctx;
        r_e_ctx <= r_d_ctx;
        r_e_sq  <= r_d_ctx.s * r_d_ctx.s;
        r_f_ctx <= r_e_ctx;
        r_f_v   <= ONE_SQ - r_e_sq[SW-1:0];
    end

    assign sq_v[0]   = r_f_valid;
    assign sq_r[0]   = r_f_v;
    assign sq_res[0] = '0;
    assign sq_c[0]   = r_f_ctx;

    for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
        wth_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_pos   (6'(SQRT_TOP - 2 * i)),
            .i_valid (sq_v[i]),
            .i_v     (sq_r[i]),
            .i_res   (sq_res[i]),
            .i_ctx   (sq_c[i]),
            .o_valid (sq_v[i+1]),
            .o_v     (sq_r[i+1]),
            .o_res   (sq_res[i+1]),
            .o_ctx   (sq_c[i+1])
        );
    end

    // asin(s) as the angle of (c, s)
    always_comb begin
        vec_ctx0   = sq_c[SQRT_STEPS];
        vec_ctx0.c = sq_res[SQRT_STEPS][QW-1:0];
    end

    assign vec_v[0] = sq_v[SQRT_STEPS];
    assign vec_x[0] = signed'({{(CW-QW){1'b0}}, sq_res[SQRT_STEPS][QW-1:0]});
    assign vec_y[0] = signed'({{(CW-32){sq_c[SQRT_STEPS].s[31]}}, sq_c[SQRT_STEPS].s});
    assign vec_z[0] = '0;
    assign vec_c[0] = vec_ctx0;

    for (genvar i = 0; i < NR; i++) begin : g_vec
        wth_vec_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (STG_W'(i)),
            .i_valid (vec_v[i]),
            .i_x     (vec_x[i]),
            .i_y     (vec_y[i]),
            .i_z     (vec_z[i]),
            .i_ctx   (vec_c[i]),
            .o_valid (vec_v[i+1]),
            .o_x     (vec_x[i+1]),
            .o_y     (vec_y[i+1]),
            .o_z     (vec_z[i+1]),
            .o_ctx   (vec_c[i+1])
        );
    end

    // round the angle to 16 bits, form both ground speed products
    assign zr = vec_z[NR] + 34'sd32768;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else begin
            r_p_valid <= vec_v[NR];
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_ctx <= vec_c[NR];
        r_p_p1  <= vec_c[NR].tas * vec_c[NR].c;
        r_p_p2  <= signed'({1'b0, vec_c[NR].ws}) * vec_c[NR].cs;
        r_p_hd  <= vec_c[NR].crs + zr[31:16];
    end

    // combine, round half up and saturate the ground speed
    assign sum = signed'({3'b000, r_p_p1}) - signed'({r_p_p2[48], r_p_p2})
               + 50'sd536870912;
    assign g   = sum >>> 30;

    always_comb begin
        priority if (g > 50'sd131071) begin
            gs_sat = 18'sd131071;
        end else if (g < -50'sd131072) begin
            gs_sat = -18'sd131072;
        end else begin
            gs_sat = g[17:0];
        end
    end

    always_comb begin
        priority if (r_p_ctx.low) begin
            stat = ST_SLOW;
        end else if (r_p_ctx.kite) begin
            stat = ST_STRONG;
        end else begin
            stat = ST_SOLVED;
        end
    end

    // drive the result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_status <= stat;
        unique case (stat)
            ST_SLOW: begin
                r_o_heading <= '0;
                r_o_gs      <= '0;
            end
            ST_STRONG: begin
                r_o_heading <= r_p_ctx.wd + HALF_TURN;
                r_o_gs      <= '0;
            end
            default: begin
                r_o_heading <= r_p_hd;
                r_o_gs      <= gs_sat;
            end
        endcase
    end

    assign o_strobe       = r_o_valid;
    assign o_heading      = r_o_heading;
    assign o_ground_speed = r_o_gs;
    assign o_status       = r_o_status;

    // unsolved results carry no ground speed
    a_unsolved_gs : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != ST_SOLVED) |-> (o_ground_speed == 18'sd0))
        else $error("unsolved result with nonzero ground speed");

    // low airspeed gives a zero heading
    a_slow_heading : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == ST_SLOW) |-> (o_heading == 16'd0))
        else $error("low airspeed result with nonzero heading");

    // reset flushes the pipeline
    a_reset_flush : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("result strobe right after reset");

endmodule

// ----- dv/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import wth_pkg::*;

    localparam int LATENCY = 102;
    localparam int STALL_LIMIT = 5000;
    localparam logic [31:0] ATAN_TURN [32] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1, 1, 0
    };

    typedef struct packed {
        logic [15:0] ws;
        logic [15:0] tas;
        logic [15:0] wd;
        logic [15:0] crs;
    } t_wind_item;

    typedef struct packed {
        logic [15:0]        heading;
        logic signed [17:0] gs;
        t_status            status;
    } t_solution;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [15:0]        i_wind_speed;
    logic [15:0]        i_true_airspeed;
    logic [15:0]        i_wind_direction;
    logic [15:0]        i_desired_course;
    logic               o_strobe;
    logic [15:0]        o_heading;
    logic signed [17:0] o_ground_speed;
    logic [1:0]         o_status;

    t_wind_item pending_items[$];
    t_solution  expected_solutions[$];
    int         error_count = 0;
    int         idle_cycles = 0;
    int         gap_left;
    bit         stimulus_done;
    bit         hold_for_drain;

    wind_triangle_heading_core dut (.*);

    // Round toward minus infinity, as >>> does on a signed value
    function automatic longint floor_shift(longint v, int sh);
        return v >>> sh;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    // Rotation CORDIC: sine and cosine of a binary angle in Q30
    function automatic void rotate_angle(input logic [15:0] ang, output longint sn,
                                         output longint cs);
        logic [31:0] u;
        bit          flip;
        longint      x, y, z, dx, dy;
        u = {ang, 16'h0};
        flip = (u[31:30] == 2'd1) || (u[31:30] == 2'd2);
        if (flip) u += 32'h8000_0000;
        z = longint'($signed(u));
        x = longint'(GAIN_Q30);
        y = 0;
        for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(ATAN_TURN[i]);
            end else begin
                x += dx; y -= dy; z += longint'(ATAN_TURN[i]);
            end
        end
        sn = flip ? -y : y;
        cs = flip ? -x : x;
    endfunction

    // Vectoring CORDIC: angle of (x, y), 2^32 per turn
    function automatic longint vector_angle(longint x, longint y);
        longint z, dx, dy;
        z = 0;
        for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (y >= 0) begin
                x += dx; y -= dy; z += longint'(ATAN_TURN[i]);
            end else begin
                x -= dx; y += dy; z -= longint'(ATAN_TURN[i]);
            end
        end
        return z;
    endfunction

    function automatic t_solution solve_wind_triangle(t_wind_item it);
        t_solution       sol;
        longint          ws, tas, sn, cs, num, s, c, gs, a16;
        longint unsigned mag;
        ws = it.ws;
        tas = it.tas;
        if (it.tas <= TAS_MIN) begin
            sol.heading = '0; sol.gs = '0; sol.status = ST_SLOW;
            return sol;
        end
        rotate_angle(it.wd - it.crs, sn, cs);
        num = ws * sn;
        mag = (num < 0) ? -num : num;
        if (mag > (longint'(tas) << 30)) begin
            sol.heading = it.wd + HALF_TURN; sol.gs = '0; sol.status = ST_STRONG;
            return sol;
        end
        s = longint'(mag / tas);
        if (num < 0) s = -s;
        c = longint'(int_sqrt((64'd1 << 60) - longint'(s * s)));
        a16 = floor_shift(vector_angle(c, s) + 32768, 16);
        sol.heading = it.crs + a16[15:0];
        gs = floor_shift(tas * c - ws * cs + (64'd1 << 29), 30);
        if (gs > 131071) gs = 131071;
        if (gs < -131072) gs = -131072;
        sol.gs = gs[17:0];
        sol.status = ST_SOLVED;
        return sol;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 150);
    endfunction

    function automatic logic [15:0] rand_edge16();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'd1 << $urandom_range(0, 15);
            default: return 16'($urandom);
        endcase
    endfunction

    // Random item: mostly solvable wind, some strong wind and slow airspeed
    function automatic t_wind_item rand_item();
        t_wind_item it;
        int r;
        r = $urandom_range(0, 99);
        it.wd = rand_edge16();
        it.crs = ($urandom_range(0, 9) == 0) ? it.wd ^ 16'($urandom_range(0, 3) << 14)
                                               : rand_edge16();
        if (r < 5) begin
            it.tas = 16'($urandom_range(0, 2));
            it.ws = rand_edge16();
        end else if (r < 20) begin
            it.ws = rand_edge16();
            it.tas = rand_edge16();
        end else begin
            it.tas = 16'($urandom_range(2, 65535));
            it.ws = 16'($urandom_range(0, it.tas));
        end
        return it;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Build the item list: directed corners first, then random
    initial begin
        t_wind_item it;
        pending_items.push_back('{16'd0, 16'd0, 16'd0, 16'd0});
        pending_items.push_back('{16'hFFFF, 16'd1, 16'h1234, 16'h0000});
        pending_items.push_back('{16'd100, 16'd2, 16'h0000, 16'h0000});
        pending_items.push_back('{16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        pending_items.push_back('{16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000});
        pending_items.push_back('{16'hFFFF, 16'hFFFF, 16'h8000, 16'h0000});
        pending_items.push_back('{16'hFFFF, 16'hFFFF, 16'h4000, 16'h0000});
        pending_items.push_back('{16'hFFFF, 16'hFFFF, 16'hC000, 16'h0000});
        pending_items.push_back('{16'hFFFF, 16'hFFFE, 16'h4000, 16'h0000});
        pending_items.push_back('{16'd2000, 16'd1000, 16'h4000, 16'h1000});
        pending_items.push_back('{16'd2000, 16'd1000, 16'h1000, 16'h1000});
        pending_items.push_back('{16'd1000, 16'd2000, 16'h2000, 16'hF000});
        pending_items.push_back('{16'd1000, 16'd2000, 16'h6000, 16'hA000});
        pending_items.push_back('{16'd4000, 16'd300, 16'h8000, 16'h0000});
        pending_items.push_back('{16'd4000, 16'd300, 16'h0000, 16'h0000});
        pending_items.push_back('{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA});
        pending_items.push_back('{16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555});
        pending_items.push_back('{16'd3, 16'd2, 16'h4000, 16'h0000});
        pending_items.push_back('{16'd2, 16'd2, 16'h4000, 16'h0000});
        repeat (1330) begin
            it = rand_item();
            pending_items.push_back(it);
        end
    end

    // Drive items; pause once mid-run until every result is back
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            i_wind_speed <= '0;
            i_true_airspeed <= '0;
            i_wind_direction <= '0;
            i_desired_course <= '0;
            gap_left <= 0;
            hold_for_drain <= 1'b0;
            stimulus_done <= 1'b0;
        end else begin
            if (start && !busy) void'(pending_items.pop_front());
            if (pending_items.size() == 700 && !hold_for_drain && start && !busy) begin
                hold_for_drain <= 1'b1;
                start <= 1'b0;
            end else if (hold_for_drain && expected_solutions.size() != 0) begin
                start <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end else if (start && busy) begin
                start <= 1'b1;
            end else if (pending_items.size() == 0) begin
                start <= 1'b0;
                stimulus_done <= 1'b1;
            end else begin
                start <= 1'b1;
                {i_wind_speed, i_true_airspeed, i_wind_direction, i_desired_course}
                    <= pending_items[0];
                gap_left <= pick_gap();
            end
        end
    end

    // Predict on acceptance, check on strobe
    always @(posedge i_clk) begin
        t_solution want;
        if (i_rst_n) begin
            if (start && !busy)
                expected_solutions.push_back(solve_wind_triangle(
                    {i_wind_speed, i_true_airspeed, i_wind_direction, i_desired_course}));
            if (o_strobe) begin
                if (expected_solutions.size() == 0) begin
                    report_mismatch("unexpected result", o_heading, -1);
                end else begin
                    want = expected_solutions.pop_front();
                    if (o_heading !== want.heading)
                        report_mismatch("heading", o_heading, want.heading);
                    if (o_ground_speed !== want.gs)
                        report_mismatch("ground_speed", o_ground_speed, want.gs);
                    if (o_status !== want.status)
                        report_mismatch("status", o_status, want.status);
                end
            end
            idle_cycles <= ((start && !busy) || o_strobe) ? 0 : idle_cycles + 1;
        end
    end

    // Watchdog on handshake activity
    always @(posedge i_clk) begin
        if (idle_cycles > STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stimulus_done && expected_solutions.size() == 0);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
